[rtl/irc_pkg.sv]
`default_nettype none

package irc_pkg;

    localparam int ENTRY_W   = 24;
    localparam int PIX_W     = 18;
    localparam int OUT_W     = 18;
    localparam int TSIZE_W   = 11;
    localparam int DEN_W     = 25;
    localparam int DIV_STEPS = OUT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_CAL_EN     = 1'b1;

    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = 11'd256;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_TOP,
        CLS_DIVIDE,
        CLS_LOOKUP
    } irc_cls_t;

    typedef struct packed {
        logic capture;
        logic classify;
        logic interp;
        logic scale;
        logic check;
        logic div_step;
        logic load_out;
    } irc_cmd_t;

    typedef struct packed {
        irc_cls_t cls;
        logic     interp_low;
        logic     ovf;
    } irc_status_t;

endpackage

`default_nettype wire

[rtl/irc_datapath.sv]
`default_nettype none

module irc_datapath #(
    parameter int MAX_ENTRIES   = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire irc_pkg::irc_cmd_t             cmd,
    output irc_pkg::irc_status_t               status,
    input  wire logic                          in_op,
    input  wire logic [irc_pkg::ENTRY_W-1:0]   in_entry,
    input  wire logic                          in_restart,
    input  wire logic [irc_pkg::PIX_W-1:0]     in_pixel,
    input  wire logic                          in_last,
    input  wire logic [irc_pkg::TSIZE_W-1:0]   table_size,
    input  wire logic                          cal_en,
    output logic [irc_pkg::OUT_W-1:0]          out_mapped,
    output logic                               out_table_valid,
    output logic                               out_last
);

    import irc_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > TSIZE_W) ? CW : TSIZE_W;
    localparam int IW = ENTRY_W + FRACTION_BITS;
    localparam int NW = IW + 10;
    localparam int RW = DEN_W + OUT_W;
    localparam int XW = (NW > RW) ? NW : RW;
    localparam int TW = 26 + FRACTION_BITS;
    localparam int TOP_OFS = (22 * (1 << FRACTION_BITS) + 9) / 20;

    logic [ENTRY_W-1:0] curve_mem [MAX_ENTRIES];

    logic [CW-1:0]      load_count_reg, load_count_next;
    logic               order_ok_reg, order_ok_next;
    logic [ENTRY_W-1:0] first_reg, first_next;
    logic [ENTRY_W-1:0] last_reg, last_next;
    logic               wr_en;
    logic [CW-1:0]      wr_idx;

    logic [PIX_W-1:0]   pix_reg;
    logic               last_in_reg;
    logic [ENTRY_W-1:0] lo_reg, hi_reg;
    logic [IW-1:0]      interp_reg;
    logic [NW-1:0]      n_reg;
    logic [DEN_W-1:0]   d_reg;
    logic [RW-1:0]      rem_reg, dsh_reg;
    logic [OUT_W-1:0]   res_reg;
    logic [OUT_W-1:0]   out_mapped_reg;
    logic               out_tv_reg, out_last_reg;

    logic [LW-1:0]      ts_ext;
    logic [LW-1:0]      s_wide;
    logic [CW-1:0]      s_eff;
    logic               table_ok;

    logic [27:0]        p_x1000;
    logic               tiny;
    logic [TW-1:0]      p_x100, s_x100;
    logic               top_end;
    irc_cls_t           cls;
    logic [OUT_W:0]     top_val;
    logic [OUT_W-1:0]   top_sat;
    logic [NW-1:0]      n_ident, n_cal;
    logic [DEN_W-1:0]   d_ident, d_cal;

    logic [PIX_W-1:0]   cell_c;
    logic [AW-1:0]      addr_lo, addr_hi;
    logic [ENTRY_W-1:0] diff;
    logic [IW-1:0]      interp_next;
    logic [IW-1:0]      base;
    logic [IW-1:0]      num;
    logic [ENTRY_W-1:0] span;
    logic               interp_low;
    logic               ovf;
    logic               ge;

    // curve bookkeeping on load words
    always_comb
    begin
        load_count_next = load_count_reg;
        order_ok_next   = order_ok_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        wr_idx          = in_restart ? '0 : load_count_reg;
        wr_en           = 1'b0;
        if (cmd.capture && in_op == OP_LOAD && wr_idx < CW'(MAX_ENTRIES))
        begin
            wr_en = 1'b1;
            if (wr_idx == '0)
            begin
                order_ok_next = 1'b1;
                first_next    = in_entry;
            end
            else if (in_entry <= last_reg)
            begin
                order_ok_next = 1'b0;
            end
            last_next       = in_entry;
            load_count_next = wr_idx + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            order_ok_reg   <= 1'b1;
            first_reg      <= '0;
            last_reg       <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            order_ok_reg   <= order_ok_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
        end
    end

    // curve memory: one write port, two registered read ports
    assign cell_c  = pix_reg >> FRACTION_BITS;
    assign addr_lo = cell_c[AW-1:0];
    assign addr_hi = addr_lo + AW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_idx[AW-1:0]] <= in_entry;
        end
        lo_reg <= curve_mem[addr_lo];
        hi_reg <= curve_mem[addr_hi];
    end

    // effective size and table validity
    assign ts_ext   = LW'(table_size);
    assign s_wide   = (ts_ext < LW'(256)) ? LW'(256) :
                      (ts_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : ts_ext;
    assign s_eff    = s_wide[CW-1:0];
    assign table_ok = order_ok_reg && ts_ext >= LW'(256) &&
                      ts_ext <= LW'(MAX_ENTRIES) && LW'(load_count_reg) == ts_ext;

    // pixel classification
    assign p_x1000 = 28'(pix_reg) * 28'd1000;
    assign tiny    = p_x1000 < (28'd1 << FRACTION_BITS);
    assign p_x100  = TW'(pix_reg) * TW'(100);
    assign s_x100  = TW'(s_eff) * TW'(100);
    assign top_end = p_x100 > ((s_x100 - TW'(101)) << FRACTION_BITS);

    always_comb
    begin
        if ((cal_en && !table_ok) || tiny)
        begin
            cls = CLS_ZERO;
        end
        else if (top_end)
        begin
            cls = CLS_TOP;
        end
        else if (!cal_en)
        begin
            cls = CLS_DIVIDE;
        end
        else
        begin
            cls = CLS_LOOKUP;
        end
    end

    // top end is (s - 1.1) in fixed point, rounded half up
    assign top_val = ((OUT_W+1)'(s_eff) << FRACTION_BITS) - (OUT_W+1)'(TOP_OFS);
    assign top_sat = (top_val > (OUT_W+1)'(OUT_MAX)) ? OUT_MAX : top_val[OUT_W-1:0];

    // dividend and divisor already in round-half-up form: (2n + d) / (2d)
    assign n_ident = NW'(pix_reg) * NW'(510) + NW'(s_eff) - NW'(1);
    assign d_ident = DEN_W'(s_eff - CW'(1)) << 1;

    assign diff        = hi_reg - lo_reg;
    assign interp_next = (IW'(lo_reg) << FRACTION_BITS) +
                         IW'(diff) * IW'(pix_reg[FRACTION_BITS-1:0]);

    assign base       = IW'(first_reg) << FRACTION_BITS;
    assign interp_low = interp_reg <= base;
    assign num        = interp_reg - base;
    assign span       = last_reg - first_reg;
    assign n_cal      = (NW'(num) << 9) - (NW'(num) << 1) + NW'(span);
    assign d_cal      = DEN_W'(span) << 1;

    assign ovf = XW'(n_reg) >= (XW'(d_reg) << OUT_W);
    assign ge  = rem_reg >= dsh_reg;

    assign status.cls        = cls;
    assign status.interp_low = interp_low;
    assign status.ovf        = ovf;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg     <= in_pixel;
            last_in_reg <= in_last;
        end
        if (cmd.interp)
        begin
            interp_reg <= interp_next;
        end
        if (cmd.classify)
        begin
            n_reg <= n_ident;
            d_reg <= d_ident;
        end
        else if (cmd.scale)
        begin
            n_reg <= n_cal;
            d_reg <= d_cal;
        end
        if (cmd.check)
        begin
            rem_reg <= RW'(n_reg);
            dsh_reg <= RW'(d_reg) << (OUT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.classify)
        begin
            res_reg <= (cls == CLS_TOP) ? top_sat : '0;
        end
        else if (cmd.capture || cmd.scale)
        begin
            res_reg <= '0;
        end
        else if (cmd.check)
        begin
            res_reg <= ovf ? OUT_MAX : '0;
        end
        else if (cmd.div_step)
        begin
            res_reg <= {res_reg[OUT_W-2:0], ge};
        end
        if (cmd.load_out)
        begin
            out_mapped_reg <= res_reg;
            out_tv_reg     <= table_ok;
            out_last_reg   <= last_in_reg;
        end
    end

    assign out_mapped      = out_mapped_reg;
    assign out_table_valid = out_tv_reg;
    assign out_last        = out_last_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ((RW+1)'(rem_reg) < ((RW+1)'(dsh_reg) << 1)))
        else $error("remainder out of range during division");

    a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && in_op == OP_LOAD && in_restart) |=>
            (first_reg == last_reg && order_ok_reg && load_count_reg == CW'(1)))
        else $error("restart load did not reset curve tracking");

endmodule

`default_nettype wire

[rtl/irc_ctrl.sv]
`default_nettype none

module irc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_op,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output irc_pkg::irc_cmd_t          cmd,
    input  wire irc_pkg::irc_status_t  status
);

    import irc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_INTERP,
        ST_SCALE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == OP_LOAD) ? ST_DONE : ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                case (status.cls)
                    CLS_ZERO:   state_next = ST_DONE;
                    CLS_TOP:    state_next = ST_DONE;
                    CLS_DIVIDE: state_next = ST_CHECK;
                    CLS_LOOKUP: state_next = ST_INTERP;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = status.interp_low ? ST_DONE : ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                cnt_next  = CNT_W'(DIV_STEPS - 1);
                state_next = status.ovf ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside done state");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=>
            (state_reg == ST_DONE && out_valid_reg))
        else $error("result lost while receiver stalled");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DIV_STEPS - 1)))
        else $error("division step count out of range");

endmodule

`default_nettype wire

[rtl/inverse_response_curve_mapper.sv]
`default_nettype none

// inverse response curve mapper
// input words on s_axis: tuser selects a curve load (0) or a pixel map (1).
// load words append an entry to the curve memory (restart bit makes it entry
// zero); map words run the pixel through the inverse curve with linear
// interpolation and normalize by the curve span, or with calibration off
// scale it by the table size. every input word gives one output word on
// m_axis carrying the mapped value and table-valid flag, tlast copied through.
// a load word goes from acceptance to the done state and then to the output
// register; a map word passes the classify state, where zero and top-end
// results finish, while calibrated pixels go on through the memory read,
// interpolation, scaling, overflow check and 18 restoring divider steps of
// one quotient bit each. one word is in flight at a time.
// the output register holds a finished word while m_axis_tready is low; the
// next input word is accepted meanwhile and waits only when its own result
// is ready before the register has drained.
// reset clears the curve bookkeeping (count, order flag, first and last
// entry) and sets table_size to 256 and calibration on; the curve memory is
// not cleared and holds garbage until loaded. config registers sit on the
// apb port: table_size at 0x0, calibration_enabled at 0x4.
module inverse_response_curve_mapper #(
    parameter int MAX_ENTRIES   = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_value[23:0], restart_load[24], pixel_value[42:25], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // operation
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mapped_value[17:0], table_valid[18], zero pad
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import irc_pkg::*;

    logic [TSIZE_W-1:0] table_size_reg;
    logic               cal_en_reg;
    logic               cfg_wr;
    irc_cmd_t           cmd;
    irc_status_t        status;
    logic [OUT_W-1:0]   mapped;
    logic               table_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            cal_en_reg     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TABLE_SIZE: table_size_reg <= pwdata[TSIZE_W-1:0];
                REG_CAL_EN:     cal_en_reg     <= pwdata[0];
                default:        cal_en_reg     <= cal_en_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TABLE_SIZE: prdata = 32'(table_size_reg);
            REG_CAL_EN:     prdata = 32'(cal_en_reg);
            default:        prdata = '0;
        endcase
    end

    irc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    irc_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_op           (s_axis_tuser),
        .in_entry        (s_axis_tdata[23:0]),
        .in_restart      (s_axis_tdata[24]),
        .in_pixel        (s_axis_tdata[42:25]),
        .in_last         (s_axis_tlast),
        .table_size      (table_size_reg),
        .cal_en          (cal_en_reg),
        .out_mapped      (mapped),
        .out_table_valid (table_valid),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, table_valid, mapped};

endmodule

`default_nettype wire

[verif/inverse_response_curve_mapper_tb.sv]
`timescale 1ns / 1ps

module inverse_response_curve_mapper_tb;
    import irc_pkg::*;

    localparam int CURVE_DEPTH  = 1024;
    localparam int FRAC_BITS    = 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1_200_000;

    typedef struct {
        logic               op;
        logic [ENTRY_W-1:0] entry;
        logic               restart;
        logic [PIX_W-1:0]   pixel;
        logic               last;
    } in_word_t;

    typedef struct {
        logic [OUT_W-1:0] mapped;
        logic             valid;
        logic             last;
    } out_word_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    inverse_response_curve_mapper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // curve bookkeeping and register copies for prediction
    logic [ENTRY_W-1:0] curve_mem [0:CURVE_DEPTH-1];
    int unsigned        curve_count = 0;
    logic [ENTRY_W-1:0] prev_ent    = '0;
    logic [ENTRY_W-1:0] first_ent   = '0;
    logic [ENTRY_W-1:0] last_ent    = '0;
    logic               order_good  = 1'b1;
    logic [TSIZE_W-1:0] cfg_size    = TABLE_SIZE_RST;
    logic               cfg_cal     = 1'b1;

    in_word_t    pending_words [$];
    out_word_t   linearized_q [$];
    in_word_t    word_on_bus;
    int unsigned words_queued = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    logic        src_steady   = 1'b0;
    logic        sink_steady  = 1'b0;

    function automatic longint unsigned div_nearest(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(longint unsigned v);
        return (v > OUT_MAX) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    function automatic logic curve_complete();
        return order_good && cfg_size >= 256 && cfg_size <= CURVE_DEPTH &&
               curve_count == cfg_size;
    endfunction

    function automatic void apply_load(logic [ENTRY_W-1:0] v, logic restart);
        if (restart)
            curve_count = 0;
        if (curve_count >= CURVE_DEPTH)
            return;
        if (curve_count == 0)
        begin
            order_good = 1'b1;
            first_ent  = v;
        end
        else if (v <= prev_ent)
            order_good = 1'b0;
        curve_mem[curve_count] = v;
        prev_ent = v;
        last_ent = v;
        curve_count++;
    endfunction

    function automatic logic [OUT_W-1:0] linearize(logic [PIX_W-1:0] pix);
        longint unsigned one, s, p, c, a, lo, hi, interp, base, span;
        one = 64'd1 << FRAC_BITS;
        s   = (cfg_size < 256) ? 256 : (cfg_size > CURVE_DEPTH) ? CURVE_DEPTH : cfg_size;
        p   = pix;
        if (cfg_cal && !curve_complete())
            return '0;
        if (p * 1000 < one)
            return '0;
        // top end clamps to size - 1.1
        if (p * 100 > (100 * s - 101) * one)
            return sat_out(div_nearest((10 * s - 11) * one, 10));
        if (!cfg_cal)
            return sat_out(div_nearest(255 * p, s - 1));
        c = p >> FRAC_BITS;
        a = p & (one - 1);
        if (c + 1 >= CURVE_DEPTH)
            return '0;
        lo     = curve_mem[c];
        hi     = curve_mem[c + 1];
        interp = lo * (one - a) + hi * a;
        base   = first_ent;
        base   = base << FRAC_BITS;
        if (interp <= base || last_ent <= first_ent)
            return '0;
        span = last_ent;
        span = span - first_ent;
        return sat_out(div_nearest(255 * (interp - base), span));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(int unsigned size);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return PIX_W'($urandom_range(0, size * 256 - 1));
        if (r < 8)
            return PIX_W'($urandom_range((size - 2) * 256, size * 256 + 300));
        if (r < 9)
            return PIX_W'($urandom_range(0, 600));
        return PIX_W'($urandom);
    endfunction

    // input side: present queued words with random gaps
    always @(posedge clk)
    begin : drive
        out_word_t exp_w;
        logic      next_valid;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (word_on_bus.op == OP_LOAD)
                begin
                    apply_load(word_on_bus.entry, word_on_bus.restart);
                    exp_w.mapped = '0;
                end
                else
                    exp_w.mapped = linearize(word_on_bus.pixel);
                exp_w.valid = curve_complete();
                exp_w.last  = word_on_bus.last;
                linearized_q.push_back(exp_w);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_words.size() != 0)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_axis_tdata <= {5'd0, word_on_bus.pixel, word_on_bus.restart,
                                     word_on_bus.entry};
                    s_axis_tuser <= word_on_bus.op;
                    s_axis_tlast <= word_on_bus.last;
                    next_valid = 1'b1;
                    src_gap = src_steady ? 0 : pick_gap();
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // output side: random stalls, compare each word with the oldest prediction
    always @(posedge clk)
    begin : observe
        out_word_t exp_w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (linearized_q.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected output word: mapped=%0d valid=%0d last=%0d",
                                 m_axis_tdata[17:0], m_axis_tdata[18], m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    exp_w = linearized_q.pop_front();
                    if (m_axis_tdata[17:0] !== exp_w.mapped ||
                        m_axis_tdata[18] !== exp_w.valid ||
                        m_axis_tlast !== exp_w.last)
                    begin
                        if (error_count < 10)
                            $display("mismatch: expected mapped=%0d valid=%0d last=%0d,",
                                     exp_w.mapped, exp_w.valid, exp_w.last,
                                     " got mapped=%0d valid=%0d last=%0d",
                                     m_axis_tdata[17:0], m_axis_tdata[18], m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 4) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_word(in_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_load(logic [ENTRY_W-1:0] v, logic restart);
        in_word_t w;
        w.op      = OP_LOAD;
        w.entry   = v;
        w.restart = restart;
        w.pixel   = PIX_W'($urandom);
        w.last    = 1'($urandom_range(0, 1));
        push_word(w);
    endtask

    task automatic push_map(logic [PIX_W-1:0] pix);
        in_word_t w;
        w.op      = OP_MAP;
        w.entry   = ENTRY_W'($urandom);
        w.restart = 1'($urandom_range(0, 1));
        w.pixel   = pix;
        w.last    = ($urandom_range(0, 3) == 0);
        push_word(w);
    endtask

    // rising curve, restart on the first entry; flaw_at >= 0 breaks the order there
    task automatic load_rising(int n, int flaw_at, int unsigned step_lo, int unsigned step_hi);
        int unsigned v;
        v = $urandom_range(0, 100000);
        for (int i = 0; i < n; i++)
        begin
            if (i == flaw_at)
                v = v - $urandom_range(0, (v < 5000) ? v : 5000);
            else if (i != 0)
                v = v + $urandom_range(step_lo, step_hi);
            push_load(v[ENTRY_W-1:0], i == 0);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || linearized_q.size() != 0);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TABLE_SIZE)
            cfg_size = val[TSIZE_W-1:0];
        else
            cfg_cal = val[0];
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned kind, size, eff, n, round_idx;
        in_word_t    w;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty curve in calibrated mode maps to zero
        push_map(18'd0);
        push_map(18'h3FFFF);
        // first load after reset lands at index zero even without restart
        push_load(24'hFFFFFF, 1'b0);
        push_load(24'h000000, 1'b0);
        push_map(18'h2AAAA);
        drain();

        write_reg(REG_CAL_EN, 32'd0);
        push_map(18'd0);
        push_map(18'd1);
        push_map(18'd65277);
        push_map(18'd65278);
        push_map(18'h15555);
        push_map(18'h3FFFF);
        drain();

        write_reg(REG_TABLE_SIZE, 32'd1024);
        push_map(18'd261885);
        push_map(18'd261886);
        push_map(18'h2AAAA);
        push_map(18'd256);
        drain();

        // sizes outside the legal range clamp
        write_reg(REG_TABLE_SIZE, 32'd0);
        push_map(18'd65278);
        push_map(18'd300);
        drain();
        write_reg(REG_TABLE_SIZE, 32'd2047);
        push_map(18'h3FFFF);
        push_map(18'd131072);
        drain();

        words_queued = 0;
        round_idx    = 0;
        while (words_queued < RANDOM_ITEMS)
        begin
            drain();
            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            kind = (round_idx == 0) ? 10 : $urandom_range(0, 9);
            round_idx++;
            if (kind <= 5)
            begin
                size = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 320) : 256;
                write_reg(REG_TABLE_SIZE, size);
                write_reg(REG_CAL_EN, 32'd1);
                load_rising(size, -1, 1, 15000);
                n = $urandom_range(40, 90);
                repeat (n) push_map(pick_pixel(size));
            end
            else if (kind == 6)
            begin
                size = 256;
                write_reg(REG_TABLE_SIZE, size);
                write_reg(REG_CAL_EN, 32'd1);
                case ($urandom_range(0, 3))
                    0: load_rising(size, $urandom_range(1, size - 1), 1, 15000);
                    1: load_rising(size - $urandom_range(1, 5), -1, 1, 15000);
                    2: load_rising(size + $urandom_range(1, 5), -1, 1, 15000);
                    default:
                    begin
                        // partial curve, then a restart that completes it
                        load_rising($urandom_range(10, 200), -1, 1, 15000);
                        load_rising(size, -1, 1, 15000);
                    end
                endcase
                repeat (30) push_map(pick_pixel(size));
            end
            else if (kind <= 8)
            begin
                case ($urandom_range(0, 6))
                    0: size = 0;
                    1: size = 255;
                    2: size = 256;
                    3: size = $urandom_range(257, 1023);
                    4: size = 1024;
                    5: size = 1025;
                    default: size = 2047;
                endcase
                eff = (size < 256) ? 256 : (size > CURVE_DEPTH) ? CURVE_DEPTH : size;
                write_reg(REG_TABLE_SIZE, size);
                write_reg(REG_CAL_EN, 32'd0);
                repeat (60) push_map(pick_pixel(eff));
            end
            else if (kind == 9)
            begin
                write_reg(REG_TABLE_SIZE, $urandom_range(0, 2047));
                write_reg(REG_CAL_EN, $urandom_range(0, 1));
                repeat (60)
                begin
                    w.op      = 1'($urandom_range(0, 1));
                    w.entry   = ENTRY_W'($urandom);
                    w.restart = ($urandom_range(0, 3) == 0);
                    w.pixel   = PIX_W'($urandom);
                    w.last    = 1'($urandom_range(0, 1));
                    push_word(w);
                end
            end
            else
            begin
                // largest curve, with a few loads past the end of the memory
                write_reg(REG_TABLE_SIZE, CURVE_DEPTH);
                write_reg(REG_CAL_EN, 32'd1);
                load_rising(CURVE_DEPTH + 6, -1, 8200, 16100);
                repeat (80) push_map(pick_pixel(CURVE_DEPTH));
            end
        end

        drain();
        repeat (40) @(negedge clk);
        if (linearized_q.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/irc_pkg.sv
rtl/irc_datapath.sv
rtl/irc_ctrl.sv
rtl/inverse_response_curve_mapper.sv
verif/inverse_response_curve_mapper_tb.sv
